// ===== hdl/srbp_pkg.sv =====
// Shared types and constants for the SPI receive buffer ports block.
// Holds the transfer payload structs, operation codes and register indexes.
// No dependencies.
package srbp_pkg;

	localparam int WORD_W = 32;

	// Operation codes carried in the input item
	localparam logic [1:0] OP_READ    = 2'd0;
	localparam logic [1:0] OP_WRITE   = 2'd1;
	localparam logic [1:0] OP_CONTROL = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_CARD_PORT     = 2'd0;
	localparam logic [1:0] CFG_ENHANCED_MASK = 2'd1;
	localparam logic [1:0] CFG_ENABLED_MASK  = 2'd2;
	localparam logic [1:0] CFG_WIDTH_MODES   = 2'd3;

	localparam int CFG_DATA_W = 8;

	// Reply seen on a port with no slave attached
	localparam logic [WORD_W-1:0] NO_DEVICE_WORD = '1;

	typedef struct packed {
		logic [1:0]        operation;
		logic [1:0]        port_index;
		logic [WORD_W-1:0] tx_word;
		logic [WORD_W-1:0] rx_word;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic              rx_full;
		logic              overflow;
	} out_item_t;

endpackage

// ===== hdl/srbp_store.sv =====
// Receive word store shared by all ports: one write and one read per cycle.
// Read data is registered on step; entries never written since reset
// read as zero. Depends on srbp_pkg.
module srbp_store #(
	parameter int WORDS  = 16,
	parameter int ADDR_W = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          rd_en,
	input  logic [ADDR_W-1:0]             rd_addr,
	input  logic                          wr_en,
	input  logic [ADDR_W-1:0]             wr_addr,
	input  logic [srbp_pkg::WORD_W-1:0]   wr_data,
	output logic [srbp_pkg::WORD_W-1:0]   rd_data
);

	logic [srbp_pkg::WORD_W-1:0] mem [WORDS];
	logic [WORDS-1:0]            vld_q;
	logic [srbp_pkg::WORD_W-1:0] rd_word_q;
	logic                        rd_hit_q;

	// storage array and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (step && rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	// written-since-reset marks; an unmarked entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (step) begin
				rd_hit_q <= rd_en && vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_hit_q ? rd_word_q : '0;

endmodule

// ===== hdl/spi_receive_buffer_ports_core.sv =====
// Top level of the SPI receive buffer ports block.
// Depends on srbp_pkg and srbp_store.
//
// Usage: register-bus style accesses arrive on the input channel (in_valid,
// in_stall, in_data); each access is a read of a port's receive buffer, a
// write transfer that stores the slave's reply word, or a control access.
// Every access returns exactly one result (read data, receive-full and
// overflow flags of the accessed port) on the output channel (out_valid,
// out_stall, out_data).
// An accepted access is held in the input stage register, then moves into
// the result register, where out_valid rises. Throughput: one access per
// cycle while the result is not stalled; the pointer and flag update plus
// the store access of one item are done between the input stage register
// and the result register. Configuration (card port, enhanced mask, enabled
// mask, width modes) is written through cfg_write/cfg_index/cfg_data; the
// user must write it only while no access is in flight; the block does not
// enforce this. Reset clears configuration, pointers and flags; the store
// reads as zero until written, with no clearing pass.
// When the receiver stalls, the result holds and one more access can be
// taken into the input stage; after that in_stall rises.
module spi_receive_buffer_ports_core #(
	parameter int PORT_COUNT   = 4,
	parameter int BUFFER_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  srbp_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output srbp_pkg::out_item_t               out_data,
	input  logic                              cfg_write,
	input  logic [1:0]                        cfg_index,
	input  logic [srbp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int PIW       = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
	localparam int AW        = $clog2(BUFFER_DEPTH);
	localparam int SLOTS     = 1 << AW;
	localparam int MEM_WORDS = PORT_COUNT * SLOTS;
	localparam int MAW       = $clog2(MEM_WORDS);
	localparam logic [AW-1:0] LAST_SLOT = AW'(BUFFER_DEPTH - 1);

	// configuration registers
	logic [1:0] card_port_q;
	logic [3:0] enh_mask_q;
	logic [3:0] en_mask_q;
	logic [7:0] width_modes_q;

	// per-port pointers and flags
	logic [AW-1:0]         rd_ptr_q [PORT_COUNT];
	logic [AW-1:0]         wr_ptr_q [PORT_COUNT];
	logic [PORT_COUNT-1:0] full_q;
	logic [PORT_COUNT-1:0] ovf_q;

	// pipeline
	logic                in_valid_s1;
	srbp_pkg::in_item_t  in_s1;
	logic                out_valid_q;
	logic                rx_full_s2;
	logic                overflow_s2;
	logic                adv;
	logic                accept;

	// step logic
	logic [1:0]                  op;
	logic [1:0]                  port;
	logic [PIW-1:0]              idx;
	logic                        port_ok;
	logic                        enh;
	logic [AW-1:0]               cur_rp;
	logic [AW-1:0]               cur_wp;
	logic                        cur_full;
	logic                        cur_ovf;
	logic [AW-1:0]               rp_inc;
	logic [AW-1:0]               wp_inc;
	logic [AW-1:0]               nxt_rp;
	logic [AW-1:0]               nxt_wp;
	logic                        nxt_full;
	logic                        nxt_ovf;
	logic                        rd_req;
	logic                        wr_req;
	logic [MAW-1:0]              rd_addr;
	logic [MAW-1:0]              wr_addr;
	logic [srbp_pkg::WORD_W-1:0] reply;
	logic [srbp_pkg::WORD_W-1:0] rd_word;

	// handshake: input stage moves on when the result register is free
	assign adv       = in_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = in_valid_s1 && !adv;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// next pointer and flag values for the accessed port
	always_comb begin
		op       = in_s1.operation;
		port     = in_s1.port_index;
		idx      = PIW'(port);
		port_ok  = int'(port) < PORT_COUNT;
		enh      = enh_mask_q[port];
		cur_rp   = rd_ptr_q[idx];
		cur_wp   = wr_ptr_q[idx];
		cur_full = full_q[idx];
		cur_ovf  = ovf_q[idx];
		rp_inc   = (cur_rp == LAST_SLOT) ? '0 : cur_rp + 1'b1;
		wp_inc   = (cur_wp == LAST_SLOT) ? '0 : cur_wp + 1'b1;
		nxt_rp   = cur_rp;
		nxt_wp   = cur_wp;
		nxt_full = cur_full;
		nxt_ovf  = cur_ovf;
		case (op)
			srbp_pkg::OP_READ: begin
				if (enh) begin
					nxt_rp = rp_inc;
				end
				nxt_full = 1'b0;
			end
			srbp_pkg::OP_WRITE: begin
				if (cur_full) begin
					nxt_ovf = 1'b1;
				end else if (enh) begin
					nxt_wp   = wp_inc;
					nxt_full = (wp_inc == cur_rp);
				end else begin
					nxt_full = 1'b1;
				end
			end
			srbp_pkg::OP_CONTROL: begin
				if (!en_mask_q[port]) begin
					nxt_full = 1'b0;
					nxt_ovf  = 1'b0;
				end else if (!enh) begin
					nxt_rp = '0;
					nxt_wp = '0;
				end
			end
			default: begin
			end
		endcase
		rd_req  = port_ok && (op == srbp_pkg::OP_READ);
		wr_req  = port_ok && (op == srbp_pkg::OP_WRITE);
		rd_addr = MAW'({idx, cur_rp});
		wr_addr = MAW'({idx, cur_wp});
	end

	// reply word cut to the port's width; all ones without a device
	always_comb begin
		if (port != card_port_q) begin
			reply = srbp_pkg::NO_DEVICE_WORD;
		end else if (width_modes_q[{port, 1'b1}]) begin
			reply = in_s1.rx_word;
		end else if (width_modes_q[{port, 1'b0}]) begin
			reply = {16'd0, in_s1.rx_word[15:0]};
		end else begin
			reply = {24'd0, in_s1.rx_word[7:0]};
		end
	end

	srbp_store #(
		.WORDS  (MEM_WORDS),
		.ADDR_W (MAW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.rd_en   (rd_req),
		.rd_addr (rd_addr),
		.wr_en   (adv && wr_req),
		.wr_addr (wr_addr),
		.wr_data (reply),
		.rd_data (rd_word)
	);

	// input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			in_s1 <= in_data;
		end
	end

	// result flags
	always_ff @(posedge clk) begin
		if (adv) begin
			rx_full_s2  <= port_ok && nxt_full;
			overflow_s2 <= port_ok && nxt_ovf;
		end
	end

	// valid bits, configuration and port state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1   <= 1'b0;
			out_valid_q   <= 1'b0;
			card_port_q   <= '0;
			enh_mask_q    <= '0;
			en_mask_q     <= '0;
			width_modes_q <= '0;
			full_q        <= '0;
			ovf_q         <= '0;
			for (int p = 0; p < PORT_COUNT; p++) begin
				rd_ptr_q[p] <= '0;
				wr_ptr_q[p] <= '0;
			end
		end else begin
			in_valid_s1 <= accept || (in_valid_s1 && !adv);
			out_valid_q <= adv || (out_valid_q && out_stall);
			if (cfg_write) begin
				case (cfg_index)
					srbp_pkg::CFG_CARD_PORT:     card_port_q   <= cfg_data[1:0];
					srbp_pkg::CFG_ENHANCED_MASK: enh_mask_q    <= cfg_data[3:0];
					srbp_pkg::CFG_ENABLED_MASK:  en_mask_q     <= cfg_data[3:0];
					srbp_pkg::CFG_WIDTH_MODES:   width_modes_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (adv && port_ok) begin
				rd_ptr_q[idx] <= nxt_rp;
				wr_ptr_q[idx] <= nxt_wp;
				full_q[idx]   <= nxt_full;
				ovf_q[idx]    <= nxt_ovf;
			end
		end
	end

	assign out_data.read_data = rd_word;
	assign out_data.rx_full   = rx_full_s2;
	assign out_data.overflow  = overflow_s2;

endmodule

// ===== hdl/srbp_checker.sv =====
// Port-level checks for spi_receive_buffer_ports_core, attached by bind.
// Depends on srbp_pkg.
module srbp_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input srbp_pkg::out_item_t   out_data
);

	// a stalled result stays and does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// input side only backs up behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	// an accepted transfer is followed by a valid result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 out_valid)
		else $error("no result two cycles after an input transfer");

endmodule

bind spi_receive_buffer_ports_core srbp_checker u_srbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
